// File: rtl/crcbf_pkg.sv
package crcbf_pkg;

    localparam int LENGTH_BITS = 16;

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_FRAME = 2'd1;
    localparam logic [1:0] PH_HEX   = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_NON_HEX  = 2'd2;
    localparam logic [1:0] ST_EARLY    = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  CHAR_OPEN  = 8'h5B;
    localparam logic [7:0]  CHAR_CLOSE = 8'h5D;
    localparam logic [7:0]  CHAR_NUL   = 8'h00;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    localparam int OUT_TDATA_BITS = 56;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
        logic [15:0] frame_length;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // bit 4 set for a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 5'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 5'(c - 8'h61 + 8'd10);
        else
            v = 5'd16;
        return v;
    endfunction

    function automatic logic [15:0] length_out(input logic [LENGTH_BITS-1:0] len);
        logic [63:0] wide;
        wide = 64'(len);
        return (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
    endfunction

endpackage

// File: rtl/crc16_bracket_frame_checker_unit.sv
// Checks bracketed text frames carrying a CRC-16/MODBUS trailer. Each input
// beat is one character, with tlast on the last character of a packet. Text
// before '[' is skipped; '[' through the first ']' is run through the CRC
// (reflected 0xA001, init 0xFFFF) and counted, then four hex digits of either
// case give the received CRC. Exactly one result beat comes out per packet:
// status 0 match, 1 mismatch, 2 non-hex character, 3 packet ended early (tlast
// or a zero byte before a verdict). The input is registered, parsed
// combinationally with a byte-wide CRC update, and the result lands in an output
// register, so one character is taken every clock while the output is free or
// being taken; a result beat passes through the input register and then the output register.
module crc16_bracket_frame_checker_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // byte_value
    input  logic        s_tlast,    // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [crcbf_pkg::OUT_TDATA_BITS-1:0] m_tdata
    // status[1:0], computed_crc[17:2], received_crc[33:18], frame_length[49:34], zero
);
    import crcbf_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    result_t    out_data_reg;

    logic       advance;
    logic       fire;
    logic       res_valid;
    result_t    res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    crcbf_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .byte_value    (in_byte_reg),
        .end_of_packet (in_last_reg),
        .result_valid  (res_valid),
        .result        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            out_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_BITS'({out_data_reg.frame_length,
                                       out_data_reg.received_crc,
                                       out_data_reg.computed_crc,
                                       out_data_reg.status});

endmodule

// File: rtl/crcbf_parser.sv
module crcbf_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            byte_value,
    input  logic                  end_of_packet,
    output logic                  result_valid,
    output crcbf_pkg::result_t    result
);
    import crcbf_pkg::*;

    logic [1:0]             phase_reg, phase_next;
    logic [15:0]            crc_reg, crc_next;
    logic [15:0]            acc_reg, acc_next;
    logic [2:0]             digits_reg, digits_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    logic       verdict;
    logic [1:0] st;
    logic [4:0] hv;

    always_comb
    begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        acc_next    = acc_reg;
        digits_next = digits_reg;
        len_next    = len_reg;
        verdict     = 1'b0;
        st          = ST_MATCH;
        hv          = hex_value(byte_value);

        if (phase_reg != PH_DONE)
        begin
            if (byte_value == CHAR_NUL)
            begin
                verdict = 1'b1;
                st      = ST_EARLY;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (byte_value == CHAR_OPEN)
                        begin
                            crc_next   = crc_byte(CRC_INIT, byte_value);
                            len_next   = LENGTH_BITS'(1);
                            phase_next = PH_FRAME;
                        end
                    end
                    PH_FRAME:
                    begin
                        crc_next = crc_byte(crc_reg, byte_value);
                        if (len_reg != LEN_MAX)
                            len_next = len_reg + LENGTH_BITS'(1);
                        if (byte_value == CHAR_CLOSE)
                        begin
                            phase_next  = PH_HEX;
                            acc_next    = 16'h0000;
                            digits_next = 3'd0;
                        end
                    end
                    default:
                    begin
                        if (hv[4])
                        begin
                            verdict = 1'b1;
                            st      = ST_NON_HEX;
                        end
                        else
                        begin
                            acc_next    = {acc_reg[11:0], hv[3:0]};
                            digits_next = digits_reg + 3'd1;
                            if (digits_next >= 3'd4)
                            begin
                                verdict = 1'b1;
                                st      = (acc_next == crc_reg) ? ST_MATCH : ST_MISMATCH;
                            end
                        end
                    end
                endcase
            end
            if (!verdict && end_of_packet)
            begin
                verdict = 1'b1;
                st      = ST_EARLY;
            end
        end

        result_valid        = fire && verdict;
        result.status       = st;
        result.computed_crc = crc_next;
        result.received_crc = acc_next;
        result.frame_length = length_out(len_next);

        if (end_of_packet)
        begin
            phase_next  = PH_HUNT;
            crc_next    = CRC_INIT;
            acc_next    = 16'h0000;
            digits_next = 3'd0;
            len_next    = '0;
        end
        else if (verdict)
        begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            crc_reg    <= CRC_INIT;
            acc_reg    <= 16'h0000;
            digits_reg <= 3'd0;
            len_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
        end
    end

endmodule

// File: tb/crc16_bracket_frame_checker_unit_test.sv
module crc16_bracket_frame_checker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crcbf_pkg::*;

    localparam int STALL_LIMIT  = 400;
    localparam int RANDOM_CHARS = 1250;

    typedef enum logic {K_LIT, K_DIGIT} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] ch;      // literal character, or nibble index of the running crc
        logic       last;
        logic       typed;
        result_t    res;
    } script_row_t;

    localparam result_t NONE = '0;

    localparam script_row_t SCRIPT [26] = '{
        '{K_LIT,   8'hFF,      1'b1, 1'b1, '{ST_EARLY, CRC_INIT, 16'h0000, 16'h0000}},
        '{K_LIT,   CHAR_NUL,   1'b0, 1'b1, '{ST_EARLY, CRC_INIT, 16'h0000, 16'h0000}},
        '{K_LIT,   8'h41,      1'b1, 1'b0, NONE},
        '{K_LIT,   CHAR_OPEN,  1'b0, 1'b0, NONE},
        '{K_LIT,   8'h80,      1'b0, 1'b0, NONE},
        '{K_LIT,   CHAR_CLOSE, 1'b0, 1'b0, NONE},
        '{K_DIGIT, 8'd3,       1'b0, 1'b0, NONE},
        '{K_DIGIT, 8'd2,       1'b0, 1'b0, NONE},
        '{K_DIGIT, 8'd1,       1'b0, 1'b0, NONE},
        '{K_DIGIT, 8'd0,       1'b0, 1'b0, NONE},
        '{K_LIT,   8'h7A,      1'b1, 1'b0, NONE},
        '{K_LIT,   CHAR_OPEN,  1'b0, 1'b0, NONE},
        '{K_LIT,   CHAR_CLOSE, 1'b0, 1'b0, NONE},
        '{K_LIT,   8'h66,      1'b0, 1'b0, NONE},
        '{K_LIT,   8'h46,      1'b0, 1'b0, NONE},
        '{K_LIT,   8'h30,      1'b0, 1'b0, NONE},
        '{K_LIT,   8'h39,      1'b1, 1'b0, NONE},
        '{K_LIT,   CHAR_OPEN,  1'b0, 1'b0, NONE},
        '{K_LIT,   CHAR_CLOSE, 1'b0, 1'b0, NONE},
        '{K_LIT,   8'h61,      1'b0, 1'b0, NONE},
        '{K_LIT,   8'h67,      1'b0, 1'b0, NONE},
        '{K_LIT,   CHAR_NUL,   1'b1, 1'b0, NONE},
        '{K_LIT,   CHAR_OPEN,  1'b0, 1'b0, NONE},
        '{K_LIT,   CHAR_OPEN,  1'b1, 1'b0, NONE},
        '{K_LIT,   CHAR_OPEN,  1'b0, 1'b0, NONE},
        '{K_LIT,   CHAR_NUL,   1'b1, 1'b0, NONE}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    // frame parser state as the checker should hold it
    logic [1:0]             pr_phase;
    logic [15:0]            pr_crc;
    logic [15:0]            pr_acc;
    logic [2:0]             pr_ndig;
    logic [LENGTH_BITS-1:0] pr_len;

    result_t verdicts [$];
    int      n_errors;
    int      n_chars;
    int      n_packets;
    int      tally [4];
    bit      calm;
    bit      rx_calm;

    crc16_bracket_frame_checker_unit uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bit-serial reflected crc, lsb of the character first
    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] ch);
        logic [15:0] x;
        logic        fb;
        x = c;
        for (int i = 0; i < 8; i++)
        begin
            fb = x[0] ^ ch[i];
            x  = x >> 1;
            if (fb)
                x = x ^ CRC_POLY;
        end
        return x;
    endfunction

    // msb set when the character is a hex digit
    function automatic logic [4:0] digit_code(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
            return {1'b1, ch[3:0]};
        if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            return {1'b1, 4'(ch[3:0] + 4'd9)};
        return 5'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (lower ? 8'h61 : 8'h41) + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] not_this);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == not_this);
        return b;
    endfunction

    function automatic int gap_draw();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void clear_state();
        pr_phase = PH_HUNT;
        pr_crc   = CRC_INIT;
        pr_acc   = '0;
        pr_ndig  = '0;
        pr_len   = '0;
    endfunction

    task automatic parse_char(input logic [7:0] ch, input logic last,
                              output bit fire, output result_t r);
        logic [4:0] d;
        logic [1:0] st;
        fire = 1'b0;
        st   = ST_MATCH;
        r    = '0;
        if (pr_phase != PH_DONE)
        begin
            if (ch == CHAR_NUL)
            begin
                fire = 1'b1;
                st   = ST_EARLY;
            end
            else if (pr_phase == PH_HUNT)
            begin
                if (ch == CHAR_OPEN)
                begin
                    pr_crc   = crc_next(CRC_INIT, ch);
                    pr_len   = LENGTH_BITS'(1);
                    pr_phase = PH_FRAME;
                end
            end
            else if (pr_phase == PH_FRAME)
            begin
                pr_crc = crc_next(pr_crc, ch);
                if (pr_len != LEN_MAX)
                    pr_len = pr_len + 1'b1;
                if (ch == CHAR_CLOSE)
                begin
                    pr_phase = PH_HEX;
                    pr_acc   = '0;
                    pr_ndig  = '0;
                end
            end
            else
            begin
                d = digit_code(ch);
                if (!d[4])
                begin
                    fire = 1'b1;
                    st   = ST_NON_HEX;
                end
                else
                begin
                    pr_acc  = {pr_acc[11:0], d[3:0]};
                    pr_ndig = pr_ndig + 1'b1;
                    if (pr_ndig >= 3'd4)
                    begin
                        fire = 1'b1;
                        st   = (pr_acc == pr_crc) ? ST_MATCH : ST_MISMATCH;
                    end
                end
            end
            if (!fire && last)
            begin
                fire = 1'b1;
                st   = ST_EARLY;
            end
            if (fire)
            begin
                r.status       = st;
                r.computed_crc = pr_crc;
                r.received_crc = pr_acc;
                r.frame_length = (64'(pr_len) > 64'hFFFF) ? 16'hFFFF : 16'(pr_len);
            end
        end
        if (last)
            clear_state();
        else if (fire)
            pr_phase = PH_DONE;
    endtask

    task automatic flag(input string what, input logic [15:0] got, input logic [15:0] want);
        if (n_errors < 40)
            $display("%0t: %s got %h expected %h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic check_verdict(input logic [OUT_TDATA_BITS-1:0] beat);
        result_t got;
        result_t want;
        got.status       = beat[1:0];
        got.computed_crc = beat[17:2];
        got.received_crc = beat[33:18];
        got.frame_length = beat[49:34];
        tally[got.status]++;
        if (verdicts.size() == 0)
        begin
            flag("unexpected verdict, status", 16'(got.status), 16'h0);
            return;
        end
        want = verdicts.pop_front();
        if (got.status != want.status)
            flag("status", 16'(got.status), 16'(want.status));
        if (got.computed_crc != want.computed_crc)
            flag("computed_crc", got.computed_crc, want.computed_crc);
        if (got.received_crc != want.received_crc)
            flag("received_crc", got.received_crc, want.received_crc);
        if (got.frame_length != want.frame_length)
            flag("frame_length", got.frame_length, want.frame_length);
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_char(input logic [7:0] ch, input logic last,
                             input bit typed, input result_t fixed);
        int      gap;
        bit      fire;
        result_t r;
        gap = gap_draw();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ch;
        s_tlast  = last;
        do
            @(posedge clk);
        while (!s_tready);
        parse_char(ch, last, fire, r);
        if (typed)
            verdicts.push_back(fixed);
        else if (fire)
            verdicts.push_back(r);
        n_chars++;
        if (last)
            n_packets++;
        @(negedge clk);
    endtask

    task automatic send_packet();
        logic [7:0]  pkt [$];
        logic [15:0] c;
        logic [7:0]  b;
        int          kind;
        int          n;
        kind = $urandom_range(0, 15);
        c    = CRC_INIT;
        n    = $urandom_range((kind == 15) ? 1 : 0, 4);
        repeat (n) pkt.push_back(pick_byte(CHAR_OPEN));
        if (kind != 15)
        begin
            pkt.push_back(CHAR_OPEN);
            c = crc_next(c, CHAR_OPEN);
            repeat ($urandom_range(0, 10))
            begin
                b = pick_byte(CHAR_CLOSE);
                pkt.push_back(b);
                c = crc_next(c, b);
            end
            pkt.push_back(CHAR_CLOSE);
            c = crc_next(c, CHAR_CLOSE);
            // wrong trailer
            if (kind == 12)
                c = c ^ (16'h0001 << $urandom_range(0, 15));
            for (int i = 3; i >= 0; i--)
                pkt.push_back(hex_char(c[4*i +: 4], $urandom_range(0, 1)));
            // cut short
            if (kind == 13)
            begin
                n = $urandom_range(1, pkt.size() - 1);
                repeat (n) void'(pkt.pop_back());
            end
            else
            begin
                // one character replaced by noise or a nul
                if (kind == 14)
                begin
                    n = $urandom_range(0, pkt.size() - 1);
                    pkt[n] = $urandom_range(0, 1) ? CHAR_NUL : 8'($urandom_range(0, 255));
                end
                repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (pkt[i])
            send_char(pkt[i], i == pkt.size() - 1, 1'b0, NONE);
    endtask

    initial
    begin : drain
        int k;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            k = rx_calm ? 0 : $urandom_range(0, 12);
            while (k > 0)
            begin
                m_tready = 1'b0;
                @(negedge clk);
                k--;
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            check_verdict(m_tdata);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("no beat moved for %0d cycles, %0d verdicts pending", idle, verdicts.size());
        $display("crc16_bracket_frame_checker_unit_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] ch;
        int         start;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        calm     = 1'b0;
        rx_calm  = 1'b0;
        n_errors = 0;
        n_chars  = 0;
        n_packets = 0;
        foreach (tally[i])
            tally[i] = 0;
        clear_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].kind == K_DIGIT)
                ch = hex_char(pr_crc[4*SCRIPT[i].ch[1:0] +: 4], 1'b0);
            else
                ch = SCRIPT[i].ch;
            send_char(ch, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].res);
        end

        start = n_chars;
        while (n_chars - start < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            if ($urandom_range(0, 7) == 0)
                rx_calm = !rx_calm;
            send_packet();
        end
        s_tvalid = 1'b0;

        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d characters in %0d packets, directed table then random frames",
                 n_chars, n_packets);
        $display("verdicts: %0d match, %0d mismatch, %0d bad digit, %0d cut short",
                 tally[ST_MATCH], tally[ST_MISMATCH], tally[ST_NON_HEX], tally[ST_EARLY]);
        if (n_errors == 0)
            $display("crc16_bracket_frame_checker_unit_test: done, clean");
        else
            $display("crc16_bracket_frame_checker_unit_test: done, errors");
        $finish;
    end

endmodule
